// ----- sv/mqrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mqrs_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TWO     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    localparam int unsigned SEARCH_LIMIT = 256;
    localparam int unsigned SEARCH_W = 9;

    typedef struct packed {
        logic [FIELD_W-1:0] coef_a;
        logic [FIELD_W-1:0] offset_b;
        logic [FIELD_W-1:0] value_d;
        logic [FIELD_W-1:0] modulus;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  root_small;
        logic [FIELD_W-1:0]  root_large;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_RED_D,
        S_CHECK,
        S_INV_STEP,
        S_INV_SQ,
        S_Q_MUL,
        S_EUL_CHK,
        S_EUL_STEP,
        S_EUL_SQ,
        S_EUL_DONE,
        S_SRCH_T,
        S_SRCH_TT,
        S_SRCH_W,
        S_SRCH_STEP,
        S_SRCH_SQ,
        S_SRCH_DONE,
        S_CIP_M1,
        S_CIP_M2,
        S_CIP_M3,
        S_CIP_M4,
        S_CIP_M5,
        S_CIP_SQ1,
        S_CIP_SQ2,
        S_CIP_SQ3,
        S_CIP_SQ4,
        S_CIP_NEXT,
        S_FINISH,
        S_OUT
    } state_t;

    // multiplier operation start / busy
    typedef struct packed {
        logic start;
        logic busy;
    } mul_ctl_t;

endpackage
`default_nettype wire

// ----- sv/mqrs_mulmod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial modular multiplier: one bit of y per cycle, MSB first,
// acc = 2*acc (+x) mod p. Caller keeps x below p and holds x, p steady
// until done.
module mqrs_mulmod #(
    parameter int unsigned W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire mqrs_pkg::mul_ctl_t ctl_in,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] y,
    input  wire logic [W-1:0] p,
    output logic              done,
    output logic [W-1:0]      prod
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  y_reg, y_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    dbl, dbl_r, sum, sum_r;

    function automatic logic [W:0] addm(input logic [W-1:0] u, input logic [W-1:0] v,
                                        input logic [W-1:0] m);
        logic [W:0] room;
        room = {1'b0, m} - {1'b0, v};
        if ({1'b0, u} >= room) begin
            addm = {1'b0, u} - room;
        end else begin
            addm = {1'b0, u} + {1'b0, v};
        end
    endfunction

    always_comb begin
        dbl   = addm(acc_reg, acc_reg, p);
        dbl_r = dbl;
        sum   = addm(dbl_r[W-1:0], x, p);
        sum_r = y_reg[W-1] ? sum : dbl_r;
        acc_next  = acc_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl_in.start) begin
            acc_next = '0;
            y_next   = y;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end else if (run_reg) begin
            acc_next = sum_r[W-1:0];
            y_next   = {y_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !run_reg) else $error("mulmod done while running");
    property p_nostart_busy;
        @(posedge aclk) disable iff (!aresetn) ctl_in.start |=> run_reg;
    endproperty
    a_nostart_busy: assert property (p_nostart_busy) else $error("start not taken");
    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("double done");
    a_acc_lt_p: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && !ctl_in.busy && p != '0) |-> (acc_reg < p))
        else $error("product not reduced");
endmodule
`default_nettype wire

// ----- sv/mqrs_modred.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial reduction x mod p (restoring, one bit per cycle).
module mqrs_modred #(
    parameter int unsigned W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] p,
    output logic              done,
    output logic [W-1:0]      rem
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  x_reg, x_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    sh;

    always_comb begin
        sh        = {r_reg, x_reg[W-1]};
        r_next    = r_reg;
        x_next    = x_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            r_next   = '0;
            x_next   = x;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (sh >= {1'b0, p}) begin
                r_next = W'(sh - {1'b0, p});
            end else begin
                r_next = sh[W-1:0];
            end
            x_next   = {x_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        r_reg   <= r_next;
        x_reg   <= x_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

    a_start_run: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> run_reg) else $error("reduction start lost");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("reduction double done");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !run_reg) else $error("reduction done while running");
endmodule
`default_nettype wire

// ----- sv/modular_quadratic_root_solver_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Modular quadratic root solver: a*(x+b)^2 = d (mod p), p prime.
// Input channel s_*: one transfer carries coef_a, offset_b, value_d, modulus
// as mqrs_pkg::in_item_t. Output channel m_*: one transfer per input with
// root_small, root_large, status as mqrs_pkg::out_item_t.
// Work is done one item at a time by a sequencer around a single bit-serial
// modular multiplier and a bit-serial reducer.
// The reducer first brings a, b, d below p; then come the Fermat inverse (up to
// 2W products), Euler test (up to 2W-2 products), per nonresidue candidate
// one product plus one Euler test, and the Cipolla power (up to 9W
// products). A non-prime modulus may try all 256 candidates. Special cases
// finish after the three reductions; a modulus below two gives its result the
// cycle after the transfer. A new item is taken only after the previous
// result has been delivered.
// s_ready is high only while idle. The result sits in an output register
// until m_ready takes it; a stalled receiver holds the block in that state.
// Reset (aresetn low, synchronous) returns to idle with no result pending.
module modular_quadratic_root_solver_core #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mqrs_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mqrs_pkg::out_item_t    m_data
);
    localparam int unsigned W  = WIDTH;
    localparam int unsigned FW = mqrs_pkg::FIELD_W;
    localparam int unsigned SW = mqrs_pkg::SEARCH_W;

    mqrs_pkg::state_t state_reg, state_next;

    logic [W-1:0] p_reg, p_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] d_reg, d_next;
    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] acc_reg, acc_next;   // exponent accumulator / ar
    logic [W-1:0] base_reg, base_next; // base / br
    logic [W-1:0] av_reg, av_next;
    logic [W-1:0] bv_reg, bv_next;
    logic [W-1:0] t_reg, t_next;       // candidate t = k mod p
    logic [W-1:0] w_reg, w_next;
    logic [W-1:0] tmp_reg, tmp_next;
    logic [W-1:0] e_reg, e_next;
    logic [SW-1:0] k_reg, k_next;
    logic         cip_reg, cip_next;   // Euler test within search
    mqrs_pkg::out_item_t out_reg, out_next;
    logic         ov_reg, ov_next;

    // one-cycle start pulses on state entry
    logic mul_go_reg, red_go_reg;
    logic go_again;
    logic entry;

    // multiplier interface
    mqrs_pkg::mul_ctl_t mctl;
    logic [W-1:0] mx, my;
    logic         mdone;
    logic [W-1:0] mprod;

    // reducer interface
    logic         rstart, rdone;
    logic [W-1:0] rx, rrem;

    mqrs_mulmod #(.W(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(mctl),
        .x(mx), .y(my), .p(p_reg), .done(mdone), .prod(mprod)
    );

    mqrs_modred #(.W(W)) u_red (
        .aclk(aclk), .aresetn(aresetn), .start(rstart),
        .x(rx), .p(p_reg), .done(rdone), .rem(rrem)
    );

    // modular helpers
    function automatic logic [W-1:0] addm(input logic [W-1:0] u, input logic [W-1:0] v,
                                          input logic [W-1:0] m);
        logic [W:0] room;
        room = {1'b0, m} - {1'b0, v};
        if ({1'b0, u} >= room) begin
            addm = W'({1'b0, u} - room);
        end else begin
            addm = W'({1'b0, u} + {1'b0, v});
        end
    endfunction

    function automatic logic [W-1:0] negm(input logic [W-1:0] u, input logic [W-1:0] m);
        negm = (u == '0) ? '0 : (m - u);
    endfunction

    logic [W-1:0] one_p;
    logic [W-1:0] pm1, x1, x2, nb;
    assign one_p = '1 >> (W - 1);
    assign pm1   = p_reg - one_p;
    assign nb    = negm(b_reg, p_reg);
    assign x1    = addm(acc_reg, nb, p_reg);
    assign x2    = addm(negm(acc_reg, p_reg), nb, p_reg);

    // multiplier and reducer operand selection and start pulses (outputs)
    always_comb begin
        mx = acc_reg;
        my = base_reg;
        rstart = 1'b0;
        rx = a_reg;
        case (state_reg)
            mqrs_pkg::S_RED_A: begin rx = a_reg; end
            mqrs_pkg::S_RED_B: begin rx = b_reg; end
            mqrs_pkg::S_RED_D: begin rx = d_reg; end
            mqrs_pkg::S_INV_STEP, mqrs_pkg::S_EUL_STEP, mqrs_pkg::S_SRCH_STEP: begin
                mx = acc_reg; my = base_reg;
            end
            mqrs_pkg::S_INV_SQ, mqrs_pkg::S_EUL_SQ, mqrs_pkg::S_SRCH_SQ: begin
                mx = base_reg; my = base_reg;
            end
            mqrs_pkg::S_Q_MUL:   begin mx = d_reg;  my = acc_reg; end
            mqrs_pkg::S_SRCH_TT: begin mx = t_reg;  my = t_reg; end
            mqrs_pkg::S_CIP_M1:  begin mx = acc_reg; my = base_reg; end
            mqrs_pkg::S_CIP_M2:  begin mx = av_reg; my = bv_reg; end
            mqrs_pkg::S_CIP_M3:  begin mx = tmp_reg; my = w_reg; end
            mqrs_pkg::S_CIP_M4:  begin mx = acc_reg; my = bv_reg; end
            mqrs_pkg::S_CIP_M5:  begin mx = av_reg; my = base_reg; end
            mqrs_pkg::S_CIP_SQ1: begin mx = base_reg; my = base_reg; end
            mqrs_pkg::S_CIP_SQ2: begin mx = bv_reg; my = bv_reg; end
            mqrs_pkg::S_CIP_SQ3: begin mx = tmp_reg; my = w_reg; end
            mqrs_pkg::S_CIP_SQ4: begin mx = base_reg; my = bv_reg; end
            default: begin end
        endcase
        mctl.start = mul_go_reg;
        mctl.busy  = 1'b0;
        rstart     = red_go_reg;
    end

    assign entry = (state_next != state_reg) || go_again;

    function automatic logic is_mul(input mqrs_pkg::state_t s);
        is_mul = s inside {mqrs_pkg::S_INV_STEP, mqrs_pkg::S_INV_SQ, mqrs_pkg::S_Q_MUL,
                           mqrs_pkg::S_EUL_STEP, mqrs_pkg::S_EUL_SQ, mqrs_pkg::S_SRCH_TT,
                           mqrs_pkg::S_SRCH_STEP, mqrs_pkg::S_SRCH_SQ,
                           mqrs_pkg::S_CIP_M1, mqrs_pkg::S_CIP_M2, mqrs_pkg::S_CIP_M3,
                           mqrs_pkg::S_CIP_M4, mqrs_pkg::S_CIP_M5, mqrs_pkg::S_CIP_SQ1,
                           mqrs_pkg::S_CIP_SQ2, mqrs_pkg::S_CIP_SQ3,
                           mqrs_pkg::S_CIP_SQ4};
    endfunction

    function automatic logic is_red(input mqrs_pkg::state_t s);
        is_red = s inside {mqrs_pkg::S_RED_A, mqrs_pkg::S_RED_B, mqrs_pkg::S_RED_D};
    endfunction

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        p_next = p_reg; a_next = a_reg; b_next = b_reg; d_next = d_reg;
        q_next = q_reg; acc_next = acc_reg; base_next = base_reg;
        av_next = av_reg; bv_next = bv_reg; t_next = t_reg; w_next = w_reg;
        tmp_next = tmp_reg; e_next = e_reg; k_next = k_reg; cip_next = cip_reg;
        out_next = out_reg; ov_next = ov_reg;
        go_again = 1'b0;
        case (state_reg)
            mqrs_pkg::S_IDLE: begin
                if (s_valid) begin
                    p_next = W'(s_data.modulus);
                    a_next = W'(s_data.coef_a);
                    b_next = W'(s_data.offset_b);
                    d_next = W'(s_data.value_d);
                    if (W'(s_data.modulus) < W'(2)) begin
                        out_next = '{root_small: '0, root_large: '0,
                                     status: mqrs_pkg::ST_NONE};
                        ov_next = 1'b1;
                        state_next = mqrs_pkg::S_OUT;
                    end else begin
                        state_next = mqrs_pkg::S_RED_A;
                    end
                end
            end
            mqrs_pkg::S_RED_A: if (rdone) begin a_next = rrem; state_next = mqrs_pkg::S_RED_B; end
            mqrs_pkg::S_RED_B: if (rdone) begin b_next = rrem; state_next = mqrs_pkg::S_RED_D; end
            mqrs_pkg::S_RED_D: if (rdone) begin d_next = rrem; state_next = mqrs_pkg::S_CHECK; end
            mqrs_pkg::S_CHECK: begin
                ov_next = 1'b1;
                state_next = mqrs_pkg::S_OUT;
                if (a_reg == '0) begin
                    out_next = '{root_small: '0, root_large: '0,
                                 status: mqrs_pkg::ST_INVALID};
                end else if (p_reg == W'(2)) begin
                    out_next.root_small = FW'(b_reg[0] ^ d_reg[0]);
                    out_next.root_large = FW'(b_reg[0] ^ d_reg[0]);
                    out_next.status = mqrs_pkg::ST_ONE;
                end else if (d_reg == '0) begin
                    out_next.root_small = FW'(nb);
                    out_next.root_large = FW'(nb);
                    out_next.status = mqrs_pkg::ST_ONE;
                end else begin
                    ov_next = 1'b0;
                    acc_next = one_p;
                    base_next = a_reg;
                    e_next = p_reg - W'(2);
                    state_next = e_next[0] ? mqrs_pkg::S_INV_STEP : mqrs_pkg::S_INV_SQ;
                end
            end
            mqrs_pkg::S_INV_STEP: if (mdone) begin
                acc_next = mprod; state_next = mqrs_pkg::S_INV_SQ;
            end
            mqrs_pkg::S_INV_SQ: if (mdone) begin
                base_next = mprod;
                e_next = e_reg >> 1;
                if (e_next == '0) begin
                    state_next = mqrs_pkg::S_Q_MUL;
                end else if (e_next[0]) begin
                    state_next = mqrs_pkg::S_INV_STEP;
                end else begin
                    go_again = 1'b1;
                end
            end
            mqrs_pkg::S_Q_MUL: if (mdone) begin
                q_next = mprod;
                if (mprod == '0) begin
                    out_next.root_small = FW'(nb);
                    out_next.root_large = FW'(nb);
                    out_next.status = mqrs_pkg::ST_ONE;
                    ov_next = 1'b1;
                    state_next = mqrs_pkg::S_OUT;
                end else begin
                    cip_next = 1'b0;
                    base_next = mprod;
                    state_next = mqrs_pkg::S_EUL_CHK;
                end
            end
            // generic pow(base, p>>1) entry
            mqrs_pkg::S_EUL_CHK: begin
                acc_next = one_p;
                e_next = p_reg >> 1;
                state_next = e_next[0] ? mqrs_pkg::S_EUL_STEP : mqrs_pkg::S_EUL_SQ;
            end
            mqrs_pkg::S_EUL_STEP: if (mdone) begin
                acc_next = mprod; state_next = mqrs_pkg::S_EUL_SQ;
            end
            mqrs_pkg::S_EUL_SQ: if (mdone) begin
                base_next = mprod;
                e_next = e_reg >> 1;
                if (e_next == '0) begin
                    state_next = mqrs_pkg::S_EUL_DONE;
                end else if (e_next[0]) begin
                    state_next = mqrs_pkg::S_EUL_STEP;
                end else begin
                    go_again = 1'b1;
                end
            end
            mqrs_pkg::S_EUL_DONE: begin
                if (!cip_reg) begin
                    if (acc_reg == pm1) begin
                        out_next = '{root_small: '0, root_large: '0,
                                     status: mqrs_pkg::ST_NONE};
                        ov_next = 1'b1;
                        state_next = mqrs_pkg::S_OUT;
                    end else begin
                        k_next = '0;
                        t_next = '0;
                        state_next = mqrs_pkg::S_SRCH_T;
                    end
                end else if (acc_reg == pm1) begin
                    // nonresidue found: Cipolla exponent (p>>1)+1
                    acc_next = one_p; av_next = '0;
                    base_next = t_reg; bv_next = one_p;
                    e_next = (p_reg >> 1) + one_p;
                    state_next = e_next[0] ? mqrs_pkg::S_CIP_M1 : mqrs_pkg::S_CIP_SQ1;
                end else begin
                    // next candidate; t tracks k mod p by wrapping at p
                    k_next = k_reg + 1'b1;
                    t_next = (t_reg + one_p == p_reg) ? '0 : t_reg + one_p;
                    state_next = mqrs_pkg::S_SRCH_T;
                end
            end
            mqrs_pkg::S_SRCH_T: begin
                if (k_reg == SW'(mqrs_pkg::SEARCH_LIMIT)) begin
                    out_next = '{root_small: '0, root_large: '0,
                                 status: mqrs_pkg::ST_NONE};
                    ov_next = 1'b1;
                    state_next = mqrs_pkg::S_OUT;
                end else begin
                    state_next = mqrs_pkg::S_SRCH_TT;
                end
            end
            mqrs_pkg::S_SRCH_TT: if (mdone) begin
                w_next = addm(mprod, negm(q_reg, p_reg) == '0 ? '0 : p_reg - q_reg, p_reg);
                state_next = mqrs_pkg::S_SRCH_W;
            end
            mqrs_pkg::S_SRCH_W: begin
                if (w_reg == '0) begin
                    acc_next = t_reg;
                    state_next = mqrs_pkg::S_FINISH;
                end else begin
                    cip_next = 1'b1;
                    base_next = w_reg;
                    state_next = mqrs_pkg::S_EUL_CHK;
                end
            end
            mqrs_pkg::S_SRCH_STEP, mqrs_pkg::S_SRCH_SQ, mqrs_pkg::S_SRCH_DONE: begin
                state_next = mqrs_pkg::S_IDLE;
            end
            mqrs_pkg::S_CIP_M1: if (mdone) begin tmp_next = mprod; w_next = w_reg;
                e_next = e_reg; state_next = mqrs_pkg::S_CIP_M2; t_next = mprod; end
            mqrs_pkg::S_CIP_M2: if (mdone) begin tmp_next = mprod; state_next = mqrs_pkg::S_CIP_M3; end
            mqrs_pkg::S_CIP_M3: if (mdone) begin
                tmp_next = addm(t_reg, mprod, p_reg); state_next = mqrs_pkg::S_CIP_M4;
            end
            mqrs_pkg::S_CIP_M4: if (mdone) begin
                t_next = mprod; acc_next = tmp_reg; state_next = mqrs_pkg::S_CIP_M5;
            end
            mqrs_pkg::S_CIP_M5: if (mdone) begin
                av_next = addm(t_reg, mprod, p_reg); state_next = mqrs_pkg::S_CIP_SQ1;
            end
            mqrs_pkg::S_CIP_SQ1: if (mdone) begin t_next = mprod; state_next = mqrs_pkg::S_CIP_SQ2; end
            mqrs_pkg::S_CIP_SQ2: if (mdone) begin tmp_next = mprod; state_next = mqrs_pkg::S_CIP_SQ3; end
            mqrs_pkg::S_CIP_SQ3: if (mdone) begin
                tmp_next = addm(t_reg, mprod, p_reg); state_next = mqrs_pkg::S_CIP_SQ4;
            end
            mqrs_pkg::S_CIP_SQ4: if (mdone) begin
                bv_next = addm(mprod, mprod, p_reg);
                base_next = tmp_reg;
                state_next = mqrs_pkg::S_CIP_NEXT;
            end
            mqrs_pkg::S_CIP_NEXT: begin
                e_next = e_reg >> 1;
                if (e_next == '0) begin
                    state_next = mqrs_pkg::S_FINISH;
                end else if (e_next[0]) begin
                    state_next = mqrs_pkg::S_CIP_M1;
                end else begin
                    state_next = mqrs_pkg::S_CIP_SQ1;
                end
            end
            mqrs_pkg::S_FINISH: begin
                ov_next = 1'b1;
                state_next = mqrs_pkg::S_OUT;
                if (x1 == x2) begin
                    out_next.root_small = FW'(x1); out_next.root_large = FW'(x1);
                    out_next.status = mqrs_pkg::ST_ONE;
                end else if (x1 < x2) begin
                    out_next.root_small = FW'(x1); out_next.root_large = FW'(x2);
                    out_next.status = mqrs_pkg::ST_TWO;
                end else begin
                    out_next.root_small = FW'(x2); out_next.root_large = FW'(x1);
                    out_next.status = mqrs_pkg::ST_TWO;
                end
            end
            mqrs_pkg::S_OUT: begin
                if (m_ready) begin
                    ov_next = 1'b0;
                    state_next = mqrs_pkg::S_IDLE;
                end
            end
            default: state_next = mqrs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next; a_reg <= a_next; b_reg <= b_next; d_reg <= d_next;
        q_reg <= q_next; acc_reg <= acc_next; base_reg <= base_next;
        av_reg <= av_next; bv_reg <= bv_next; t_reg <= t_next; w_reg <= w_next;
        tmp_reg <= tmp_next; e_reg <= e_next; k_reg <= k_next; cip_reg <= cip_next;
        out_reg <= out_next;
        if (!aresetn) begin
            state_reg  <= mqrs_pkg::S_IDLE;
            ov_reg     <= 1'b0;
            mul_go_reg <= 1'b0;
            red_go_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            mul_go_reg <= entry && is_mul(state_next);
            red_go_reg <= entry && is_red(state_next);
        end
    end

    assign s_ready = (state_reg == mqrs_pkg::S_IDLE);
    assign m_valid = ov_reg;
    assign m_data  = out_reg;

    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == mqrs_pkg::S_OUT)) else $error("result outside output state");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second item taken");
    a_status_roots: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == mqrs_pkg::ST_NONE ||
                     m_data.status == mqrs_pkg::ST_INVALID)) |-> (m_data.root_small == '0))
        else $error("roots set without solution");
endmodule
`default_nettype wire
